>>> src/dqsm_pkg.sv
// Shared types, codes and constants for the deque with sum and max.
`timescale 1ns / 1ps
`default_nettype none
package dqsm_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_POP_FRONT  = 2'd1,
    OP_POP_BACK   = 2'd2
  } op_code_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_code_t;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MAX = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         count;
    logic signed [31:0] total;
    logic [30:0]        largest;
  } out_t;

endpackage
`default_nettype wire

>>> src/dqsm_alu.sv
// Shared arithmetic unit: wrapping add, wrapping subtract, signed maximum.
`timescale 1ns / 1ps
`default_nettype none
module dqsm_alu (
  input  dqsm_pkg::alu_op_t op,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [31:0] y
);
  import dqsm_pkg::*;

  always_comb begin
    unique case (op)
      ALU_ADD: y = a + b;
      ALU_SUB: y = a - b;
      ALU_MAX: y = (b > a) ? b : a;
      default: y = a;
    endcase
  end

endmodule
`default_nettype wire

>>> src/dqsm_ring.sv
// Ring store: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none
module dqsm_ring #(
  parameter int unsigned DEPTH = dqsm_pkg::DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic signed [31:0]       wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic signed [31:0]       rd_data
);
  import dqsm_pkg::*;

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> src/deque_with_sum_and_max.sv
// Top level: bounded deque with running sum and max scan sequencer.
//
//  channel  | handshake         | payload
//  ---------+-------------------+---------------------------------------
//  command  | start / busy      | item   (op, value)
//  result   | done (one cycle)  | result (status, count, total, largest)
//
// Each command passes from the accept through S_SCAN, which reads and compares every
// element held after it, to the done beat in S_DONE; a removal that takes an element
// first passes through S_POPRD for its store read. The max scan reads the ring store
// once per held element through its single read port, one ahead of the compare.
// busy is high from the cycle after the accept through the done beat.
// Reset (rst, synchronous) empties the deque; store contents are not cleared.
// The receiver cannot stall: the result beat is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module deque_with_sum_and_max #(
  parameter int unsigned DEPTH = dqsm_pkg::DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  dqsm_pkg::in_t  item,
  output logic           done,
  output dqsm_pkg::out_t result
);
  import dqsm_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_POPRD = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t             state;
  logic [IW-1:0]      front;
  logic [CW-1:0]      count;
  logic signed [31:0] sum;
  logic signed [31:0] best;
  logic [IW-1:0]      ptr;
  logic [CW-1:0]      issued;
  logic               rd_pend;
  logic               pop_front;
  logic [1:0]         status;

  logic               wr_en;
  logic [IW-1:0]      rd_addr;
  logic signed [31:0] rd_data;
  alu_op_t            alu_op;
  logic signed [31:0] alu_a;
  logic signed [31:0] alu_b;
  logic signed [31:0] alu_y;

  logic [IW-1:0]      front_dec;
  logic [IW-1:0]      front_inc;
  logic [IW-1:0]      ptr_inc;
  logic [CW:0]        back_raw;
  logic [IW-1:0]      back_idx;
  logic               full;
  logic               empty;
  logic [31:0]        count_ext;

  assign front_dec = (front == '0) ? IW'(DEPTH - 1) : front - 1'b1;
  assign front_inc = (front == IW'(DEPTH - 1)) ? '0 : front + 1'b1;
  assign ptr_inc   = (ptr == IW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  // back = (front + count - 1) mod DEPTH; the raw sum stays below 2*DEPTH while not empty
  assign back_raw  = (CW+1)'(front) + (CW+1)'(count) - 1'b1;
  assign back_idx  = (back_raw >= (CW+1)'(DEPTH)) ? IW'(back_raw - (CW+1)'(DEPTH))
                                                  : IW'(back_raw);
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);

  assign wr_en   = (state == S_IDLE) && start && (item.op == OP_PUSH_FRONT) && !full;
  assign rd_addr = (state == S_IDLE) ? ((item.op == OP_POP_FRONT) ? front : back_idx)
                                     : ptr;

  always_comb begin
    alu_op = ALU_MAX;
    alu_a  = best;
    alu_b  = rd_data;
    unique case (state)
      S_IDLE: begin
        alu_op = ALU_ADD;
        alu_a  = sum;
        alu_b  = item.value;
      end
      S_POPRD: begin
        alu_op = ALU_SUB;
        alu_a  = sum;
        alu_b  = rd_data;
      end
      S_SCAN, S_DONE: begin
        alu_op = ALU_MAX;
      end
      default: begin
        alu_op = ALU_MAX;
      end
    endcase
  end

  dqsm_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  dqsm_ring #(
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (front_dec),
    .wr_data (item.value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      front   <= '0;
      count   <= '0;
      sum     <= '0;
      rd_pend <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            status    <= ST_DONE;
            pop_front <= (item.op == OP_POP_FRONT);
            best      <= '0;
            issued    <= '0;
            rd_pend   <= 1'b0;
            ptr       <= front;
            state     <= S_SCAN;
            case (item.op)
              OP_PUSH_FRONT: begin
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  front <= front_dec;
                  ptr   <= front_dec;
                  count <= count + 1'b1;
                  sum   <= alu_y;
                end
              end
              OP_POP_FRONT, OP_POP_BACK: begin
                if (empty) begin
                  status <= ST_EMPTY;
                end else begin
                  state <= S_POPRD;
                end
              end
              default: ;
            endcase
          end
        end
        S_POPRD: begin
          sum   <= alu_y;
          count <= count - 1'b1;
          if (pop_front) begin
            front <= front_inc;
            ptr   <= front_inc;
          end
          state <= S_SCAN;
        end
        S_SCAN: begin
          // reads go one ahead of the compare
          if (issued != count) begin
            ptr     <= ptr_inc;
            issued  <= issued + 1'b1;
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend) begin
            best <= alu_y;
          end
          if ((issued == count) && !rd_pend) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign count_ext      = 32'(count);
  assign busy           = (state != S_IDLE);
  assign done           = (state == S_DONE);
  assign result.status  = status;
  assign result.count   = count_ext[4:0];
  assign result.total   = sum;
  assign result.largest = best[30:0];

endmodule
`default_nettype wire

>>> tb/deque_with_sum_and_max_checker.sv
// Checker for the deque: predicts each result beat and compares it with the block.
`timescale 1ns / 1ps
module deque_with_sum_and_max_checker #(
  parameter int unsigned DEPTH = dqsm_pkg::DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  dqsm_pkg::in_t  item,
  input  logic           done,
  input  dqsm_pkg::out_t result,
  output int             errors,
  output int             outstanding
);
  import dqsm_pkg::*;

  // shadow deque
  logic signed [31:0] shadow_ring [DEPTH];
  int unsigned        shadow_head;
  int unsigned        shadow_held;
  logic signed [31:0] shadow_sum;

  out_t deque_results_due [$];
  int   mismatch_count = 0;

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  function automatic out_t apply_deque_op(in_t cmd);
    out_t        res;
    int          best;
    int unsigned slot;
    res        = '0;
    res.status = ST_DONE;
    case (cmd.op)
      OP_PUSH_FRONT: begin
        if (shadow_held >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_head              = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_ring[shadow_head] = cmd.value;
          shadow_held++;
          shadow_sum               = shadow_sum + cmd.value;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (shadow_held == 0) begin
          res.status = ST_EMPTY;
        end else begin
          slot = (cmd.op == OP_POP_FRONT) ? shadow_head
                                          : (shadow_head + shadow_held - 1) % DEPTH;
          shadow_sum = shadow_sum - shadow_ring[slot];
          if (cmd.op == OP_POP_FRONT) shadow_head = (shadow_head + 1) % DEPTH;
          shadow_held--;
        end
      end
      default: ;  // unused code: no change
    endcase
    // max over held elements, floored at zero
    best = 0;
    for (int unsigned i = 0; i < shadow_held; i++) begin
      if (shadow_ring[(shadow_head + i) % DEPTH] > best)
        best = shadow_ring[(shadow_head + i) % DEPTH];
    end
    res.count   = 5'(shadow_held);
    res.total   = shadow_sum;
    res.largest = 31'(best);
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_t due;
    if (rst) begin
      shadow_head = 0;
      shadow_held = 0;
      shadow_sum  = '0;
      deque_results_due.delete();
    end else begin
      if (done === 1'b1) begin
        if (deque_results_due.size() == 0) begin
          $display("%0t: result beat with none expected, actual %0h", $time, result);
          mismatch_count++;
        end else begin
          due = deque_results_due.pop_front();
          check_field("status",  32'(due.status),  32'(result.status));
          check_field("count",   32'(due.count),   32'(result.count));
          check_field("total",   due.total,        result.total);
          check_field("largest", 32'(due.largest), 32'(result.largest));
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        deque_results_due.push_back(apply_deque_op(item));
    end
    errors      <= mismatch_count;
    outstanding <= deque_results_due.size();
  end

endmodule

>>> tb/deque_with_sum_and_max_tb.sv
// Testbench top: command stimulus for the deque, checker hookup and verdict.
`timescale 1ns / 1ps
module deque_with_sum_and_max_tb;
  import dqsm_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         RANDOM_ITEMS = 650;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  in_t  item  = '0;
  logic busy;
  logic done;
  out_t result;
  int   errors;
  int   outstanding;

  deque_with_sum_and_max i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  deque_with_sum_and_max_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .done        (done),
    .result      (result),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // hold start high until the command beat is taken
  task automatic issue_command(input logic [1:0] op, input logic [31:0] val);
    item  <= '{op: op, value: val};
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'hffff_ffff;
      3:       return 32'($urandom_range(0, 200)) - 32'd100;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int          sent;
    int          phase_len;
    int          fill_pct;
    int          burst_left;
    bit          no_gaps;
    int unsigned r;
    logic [1:0]  op;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty removals, unused code, extremes, single-element removal
    issue_command(OP_POP_FRONT, 32'h0);
    issue_command(OP_POP_BACK, 32'hffff_ffff);
    issue_command(OP_UNUSED, 32'h1234_5678);
    issue_command(OP_PUSH_FRONT, 32'h7fff_ffff);
    issue_command(OP_POP_BACK, 32'h0);
    issue_command(OP_PUSH_FRONT, 32'h8000_0000);
    issue_command(OP_PUSH_FRONT, 32'h7fff_ffff);
    issue_command(OP_PUSH_FRONT, 32'hffff_ffff);
    issue_command(OP_UNUSED, 32'h0);
    issue_command(OP_POP_FRONT, 32'h0);
    issue_command(OP_POP_BACK, 32'h0);
    issue_command(OP_POP_FRONT, 32'h0);
    issue_command(OP_PUSH_FRONT, 32'h0);
    issue_command(OP_PUSH_FRONT, 32'hffff_fffe);
    issue_command(OP_POP_FRONT, 32'h0);
    issue_command(OP_POP_FRONT, 32'h0);
    wait_drained();

    // random: phases lean toward filling or draining so full and empty recur
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len  = $urandom_range(15, 50);
      case ($urandom_range(0, 2))
        0:       fill_pct = 85;
        1:       fill_pct = 20;
        default: fill_pct = 50;
      endcase
      no_gaps    = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(1, 12);
      repeat (phase_len) begin
        r = $urandom_range(0, 99);
        if (r < 3)             op = OP_UNUSED;
        else if (r < fill_pct) op = OP_PUSH_FRONT;
        else if (r[0])         op = OP_POP_FRONT;
        else                   op = OP_POP_BACK;
        issue_command(op, (op == OP_PUSH_FRONT) ? pick_value() : $urandom);
        sent++;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          if (!no_gaps) idle_cycles($urandom_range(1, 25));
        end
      end
      if ($urandom_range(0, 2) == 0) wait_drained();
    end
    start <= 1'b0;

    for (int k = 0; k < 1000 && outstanding != 0; k++) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> deque_with_sum_and_max.f
src/dqsm_pkg.sv
src/dqsm_alu.sv
src/dqsm_ring.sv
src/deque_with_sum_and_max.sv
tb/deque_with_sum_and_max_checker.sv
tb/deque_with_sum_and_max_tb.sv
